// ----- design/uxf_pkg.sv -----
// ----------------------------------------------------------------------------
// UART ring pair with XON/XOFF flow control - shared definitions
// Event codes, flow control characters, default sizes and the control
// bundle between the controller and the datapath.
// ----------------------------------------------------------------------------
package uxf_pkg;

  // Event codes carried in the mode field
  localparam logic [1:0] MODE_LINE_RX = 2'd0;
  localparam logic [1:0] MODE_PUT     = 2'd1;
  localparam logic [1:0] MODE_GET     = 2'd2;
  localparam logic [1:0] MODE_TX_RDY  = 2'd3;

  // Software flow control characters
  localparam logic [7:0] CH_XON  = 8'h11;
  localparam logic [7:0] CH_XOFF = 8'h13;

  // Defaults for the top level parameters
  localparam int unsigned RING_DEPTH_DEF  = 64;
  localparam int unsigned SPARE_SLOTS_DEF = 2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // take the event in, start store reads
    logic execute;  // update rings and flags, load the result register
  } uxf_cmd_t;

endpackage

// ----- design/uxf_evt_if.sv -----
// ----------------------------------------------------------------------------
// Event channel
// Carries one event (line byte, host put, host get, transmitter ready).
// ----------------------------------------------------------------------------
interface uxf_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       framing_error;
  logic       overrun_error;

  modport source (output valid, output mode, output data_byte,
                  output framing_error, output overrun_error, input ready);
  modport sink   (input valid, input mode, input data_byte,
                  input framing_error, input overrun_error, output ready);
endinterface

// ----- design/uxf_res_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Carries one result per event: line byte, host byte and status flags.
// ----------------------------------------------------------------------------
interface uxf_res_if;
  logic       valid;
  logic       ready;
  logic       line_valid;
  logic [7:0] line_byte;
  logic       host_valid;
  logic [7:0] host_byte;
  logic       put_accepted;
  logic       tx_paused;
  logic       rx_paused;

  modport source (output valid, output line_valid, output line_byte,
                  output host_valid, output host_byte, output put_accepted,
                  output tx_paused, output rx_paused, input ready);
  modport sink   (input valid, input line_valid, input line_byte,
                  input host_valid, input host_byte, input put_accepted,
                  input tx_paused, input rx_paused, output ready);
endinterface

// ----- design/uxf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the flow enable register write data.
// ----------------------------------------------------------------------------
interface uxf_cfg_if;
  logic valid;
  logic ready;
  logic flow_enable;

  modport source (output valid, output flow_enable, input ready);
  modport sink   (input valid, input flow_enable, output ready);
endinterface

// ----- design/uxf_ctrl.sv -----
// ----------------------------------------------------------------------------
// UART ring pair controller
// Sequences capture and execute of one event and tracks the result register.
// ----------------------------------------------------------------------------
module uxf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              evt_valid_i,
  input  logic              res_ready_i,
  output logic              evt_ready_o,
  output logic              res_valid_o,
  output uxf_pkg::uxf_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;
  logic   exec_go;

  assign evt_ready_o = (state_q == ST_IDLE);
  assign exec_go     = (state_q == ST_EXEC) && (!res_valid_q || res_ready_i);

  always_comb begin
    state_d     = state_q;
    res_valid_d = res_valid_q;
    if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (evt_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign cmd_o.capture = evt_valid_i && (state_q == ST_IDLE);
  assign cmd_o.execute = exec_go;

endmodule

// ----- design/uxf_dpath.sv -----
// ----------------------------------------------------------------------------
// UART ring pair datapath
// Holds both byte rings, their pointers, the flow flags and the result.
// ----------------------------------------------------------------------------
module uxf_dpath #(
  parameter int unsigned RING_DEPTH  = uxf_pkg::RING_DEPTH_DEF,
  parameter int unsigned SPARE_SLOTS = uxf_pkg::SPARE_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uxf_pkg::uxf_cmd_t cmd_i,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        data_byte_i,
  input  logic              framing_error_i,
  input  logic              overrun_error_i,
  input  logic              cfg_we_i,
  input  logic              cfg_flow_enable_i,
  output logic              line_valid_o,
  output logic [7:0]        line_byte_o,
  output logic              host_valid_o,
  output logic [7:0]        host_byte_o,
  output logic              put_accepted_o,
  output logic              tx_paused_o,
  output logic              rx_paused_o
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W:0]   FREE_MAX = (PTR_W + 1)'(RING_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W:0] ring_free(input logic [PTR_W-1:0] w,
                                               input logic [PTR_W-1:0] r);
    logic [PTR_W:0] we;
    logic [PTR_W:0] re;
    we = {1'b0, w};
    re = {1'b0, r};
    return (w >= r) ? (FREE_MAX - (we - re)) : (re - we - 1'b1);
  endfunction

  logic [7:0] rx_mem [RING_DEPTH];
  logic [7:0] tx_mem [RING_DEPTH];

  // Captured event
  logic [1:0] mode_q;
  logic [7:0] byte_q;
  logic       err_q;
  logic [7:0] rx_rd_q, tx_rd_q;

  // Ring state
  logic [PTR_W-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  logic [PTR_W-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;
  logic             rx_on_q, rx_on_d, tx_on_q, tx_on_d;
  logic             flow_en_q;

  // Result
  logic       line_valid_d, line_valid_q;
  logic [7:0] line_byte_d, line_byte_q;
  logic       host_valid_d, host_valid_q;
  logic [7:0] host_byte_d, host_byte_q;
  logic       put_acc_d, put_acc_q;
  logic       rx_we, tx_we;
  logic [PTR_W-1:0] wp_nx, rp_nx;

  always_comb begin
    rx_wp_d      = rx_wp_q;
    rx_rp_d      = rx_rp_q;
    tx_wp_d      = tx_wp_q;
    tx_rp_d      = tx_rp_q;
    rx_on_d      = rx_on_q;
    tx_on_d      = tx_on_q;
    line_valid_d = 1'b0;
    line_byte_d  = '0;
    host_valid_d = 1'b0;
    host_byte_d  = '0;
    put_acc_d    = 1'b0;
    rx_we        = 1'b0;
    tx_we        = 1'b0;
    wp_nx        = ptr_next(rx_wp_q);
    rp_nx        = ptr_next(rx_rp_q);
    case (mode_q)
      uxf_pkg::MODE_LINE_RX: begin
        if (!err_q) begin
          if (flow_en_q && tx_on_q && byte_q == uxf_pkg::CH_XOFF) begin
            tx_on_d = 1'b0;
          end else if (flow_en_q && !tx_on_q && byte_q == uxf_pkg::CH_XON) begin
            tx_on_d = 1'b1;
          end else begin
            rx_we   = 1'b1;
            rx_wp_d = wp_nx;
            if (flow_en_q && rx_on_q &&
                32'(ring_free(wp_nx, rx_rp_q)) <= 32'(SPARE_SLOTS)) begin
              line_valid_d = 1'b1;
              line_byte_d  = uxf_pkg::CH_XOFF;
              rx_on_d      = 1'b0;
            end
            // Overwrite the oldest byte when the ring wraps onto itself
            if (wp_nx == rx_rp_q) begin
              rx_rp_d = rp_nx;
            end
          end
        end
      end
      uxf_pkg::MODE_PUT: begin
        if (ptr_next(tx_wp_q) != tx_rp_q) begin
          tx_we     = 1'b1;
          tx_wp_d   = ptr_next(tx_wp_q);
          put_acc_d = 1'b1;
        end
      end
      uxf_pkg::MODE_GET: begin
        if (rx_wp_q != rx_rp_q) begin
          host_valid_d = 1'b1;
          host_byte_d  = rx_rd_q;
          rx_rp_d      = rp_nx;
          if (flow_en_q && !rx_on_q && rx_wp_q == rp_nx) begin
            line_valid_d = 1'b1;
            line_byte_d  = uxf_pkg::CH_XON;
            rx_on_d      = 1'b1;
          end
        end
      end
      default: begin
        if (tx_wp_q != tx_rp_q && (!flow_en_q || tx_on_q)) begin
          line_valid_d = 1'b1;
          line_byte_d  = tx_rd_q;
          tx_rp_d      = ptr_next(tx_rp_q);
        end
      end
    endcase
  end

  // Stores: read on capture, write on execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rx_rd_q <= rx_mem[rx_rp_q];
      tx_rd_q <= tx_mem[tx_rp_q];
    end
    if (cmd_i.execute && rx_we) begin
      rx_mem[rx_wp_q] <= byte_q;
    end
    if (cmd_i.execute && tx_we) begin
      tx_mem[tx_wp_q] <= byte_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      byte_q <= data_byte_i;
      err_q  <= framing_error_i | overrun_error_i;
    end
    if (cmd_i.execute) begin
      line_valid_q <= line_valid_d;
      line_byte_q  <= line_byte_d;
      host_valid_q <= host_valid_d;
      host_byte_q  <= host_byte_d;
      put_acc_q    <= put_acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wp_q   <= '0;
      rx_rp_q   <= '0;
      tx_wp_q   <= '0;
      tx_rp_q   <= '0;
      rx_on_q   <= 1'b1;
      tx_on_q   <= 1'b1;
      flow_en_q <= 1'b0;
    end else begin
      if (cmd_i.execute) begin
        rx_wp_q <= rx_wp_d;
        rx_rp_q <= rx_rp_d;
        tx_wp_q <= tx_wp_d;
        tx_rp_q <= tx_rp_d;
        rx_on_q <= rx_on_d;
        tx_on_q <= tx_on_d;
      end
      if (cfg_we_i) begin
        flow_en_q <= cfg_flow_enable_i;
      end
    end
  end

  assign line_valid_o   = line_valid_q;
  assign line_byte_o    = line_byte_q;
  assign host_valid_o   = host_valid_q;
  assign host_byte_o    = host_byte_q;
  assign put_accepted_o = put_acc_q;
  assign tx_paused_o    = flow_en_q & ~tx_on_q;
  assign rx_paused_o    = ~rx_on_q;

endmodule

// ----- design/uart_fifo_xon_xoff_flow.sv -----
// ----------------------------------------------------------------------------
// UART ring pair with XON/XOFF software flow control
// Receive and transmit byte rings, host put/get, line byte intake and
// transmitter feed, with XOFF/XON issue and obey.
// ----------------------------------------------------------------------------
// Timing: the capture step does the registered store read, the execute state
//   does the store write and pointer update and loads the result register.
//   One event is in flight at a time; a new event is taken only once the last
//   one has been executed. Execute holds while the output register is full;
//   capture does not.
// Reset: pointers cleared, both flow flags on, flow_enable off, stores kept.
// ----------------------------------------------------------------------------
module uart_fifo_xon_xoff_flow #(
  parameter int unsigned RING_DEPTH  = uxf_pkg::RING_DEPTH_DEF,
  parameter int unsigned SPARE_SLOTS = uxf_pkg::SPARE_SLOTS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  uxf_evt_if.sink   evt_i,
  uxf_res_if.source res_o,
  uxf_cfg_if.sink   cfg_i
);

  uxf_pkg::uxf_cmd_t cmd;

  // Configuration writes always taken; the host must write only while idle
  assign cfg_i.ready = 1'b1;

  // Controller: one event in flight, result register freed by the sink
  uxf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_i.valid),
    .res_ready_i (res_o.ready),
    .evt_ready_o (evt_i.ready),
    .res_valid_o (res_o.valid),
    .cmd_o       (cmd)
  );

  // Datapath: rings, pointers, flow flags and the result register
  uxf_dpath #(
    .RING_DEPTH  (RING_DEPTH),
    .SPARE_SLOTS (SPARE_SLOTS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .mode_i            (evt_i.mode),
    .data_byte_i       (evt_i.data_byte),
    .framing_error_i   (evt_i.framing_error),
    .overrun_error_i   (evt_i.overrun_error),
    .cfg_we_i          (cfg_i.valid),
    .cfg_flow_enable_i (cfg_i.flow_enable),
    .line_valid_o      (res_o.line_valid),
    .line_byte_o       (res_o.line_byte),
    .host_valid_o      (res_o.host_valid),
    .host_byte_o       (res_o.host_byte),
    .put_accepted_o    (res_o.put_accepted),
    .tx_paused_o       (res_o.tx_paused),
    .rx_paused_o       (res_o.rx_paused)
  );

endmodule

// ----- test/uxf_ring_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART ring pair checker
// Watches the event, result and configuration channels, keeps its own copy
// of both rings and the flow flags, and compares every result transaction
// with the oldest result owed by the block.
// ----------------------------------------------------------------------------
module uxf_ring_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  uxf_evt_if          evt_i,
  uxf_res_if          res_i,
  uxf_cfg_if          cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  // Pointers wrap on their own width, so the depth must be a power of two.
  localparam int unsigned RING  = uxf_pkg::RING_DEPTH_DEF;
  localparam int unsigned PTR_W = $clog2(RING);
  localparam int unsigned SPARE = uxf_pkg::SPARE_SLOTS_DEF;

  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic       host_valid;
    logic [7:0] host_byte;
    logic       put_accepted;
    logic       tx_paused;
    logic       rx_paused;
  } ring_result_t;

  logic [7:0]       rx_ring [RING];
  logic [7:0]       tx_ring [RING];
  logic [PTR_W-1:0] rx_wr, rx_rd, tx_wr, tx_rd;
  logic             rx_flow_on, tx_flow_on, flow_en;
  ring_result_t     owed_results [$];

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) report_mismatch($sformatf("%s expected %h got %h", name, want, got));
  endtask

  task automatic check_result(input ring_result_t want);
    check_field("line_valid", want.line_valid, res_i.line_valid);
    check_field("line_byte", want.line_byte, res_i.line_byte);
    check_field("host_valid", want.host_valid, res_i.host_valid);
    check_field("host_byte", want.host_byte, res_i.host_byte);
    check_field("put_accepted", want.put_accepted, res_i.put_accepted);
    check_field("tx_paused", want.tx_paused, res_i.tx_paused);
    check_field("rx_paused", want.rx_paused, res_i.rx_paused);
  endtask

  // Apply one event to the ring copies and return the result it owes.
  function automatic ring_result_t serve_event(input logic [1:0] mode, input logic [7:0] b,
                                               input logic ferr, input logic oerr);
    ring_result_t r;
    logic         taken;
    logic [PTR_W-1:0] room;
    r = '0;
    taken = 1'b0;
    case (mode)
      uxf_pkg::MODE_LINE_RX: begin
        if (!ferr && !oerr) begin
          if (flow_en) begin
            if (tx_flow_on && b == uxf_pkg::CH_XOFF) begin
              tx_flow_on = 1'b0;
              taken = 1'b1;
            end else if (!tx_flow_on && b == uxf_pkg::CH_XON) begin
              tx_flow_on = 1'b1;
              taken = 1'b1;
            end
          end
          if (!taken) begin
            rx_ring[rx_wr] = b;
            rx_wr = rx_wr + 1'b1;
            // free space is taken before the oldest byte gets dropped
            room = rx_rd - rx_wr - 1'b1;
            if (flow_en && rx_flow_on && room <= SPARE) begin
              r.line_valid = 1'b1;
              r.line_byte = uxf_pkg::CH_XOFF;
              rx_flow_on = 1'b0;
            end
            if (rx_wr == rx_rd) rx_rd = rx_rd + 1'b1;
          end
        end
      end
      uxf_pkg::MODE_PUT: begin
        room = tx_rd - tx_wr - 1'b1;
        if (room != 0) begin
          tx_ring[tx_wr] = b;
          tx_wr = tx_wr + 1'b1;
          r.put_accepted = 1'b1;
        end
      end
      uxf_pkg::MODE_GET: begin
        if (rx_wr != rx_rd) begin
          r.host_valid = 1'b1;
          r.host_byte = rx_ring[rx_rd];
          rx_rd = rx_rd + 1'b1;
          if (flow_en && !rx_flow_on && rx_wr == rx_rd) begin
            r.line_valid = 1'b1;
            r.line_byte = uxf_pkg::CH_XON;
            rx_flow_on = 1'b1;
          end
        end
      end
      default: begin
        if (tx_wr != tx_rd && (!flow_en || tx_flow_on)) begin
          r.line_valid = 1'b1;
          r.line_byte = tx_ring[tx_rd];
          tx_rd = tx_rd + 1'b1;
        end
      end
    endcase
    r.tx_paused = flow_en & ~tx_flow_on;
    r.rx_paused = ~rx_flow_on;
    return r;
  endfunction

  // Retire results before taking new events in, so a stray result never
  // pairs with an event accepted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wr = '0;
      rx_rd = '0;
      tx_wr = '0;
      tx_rd = '0;
      rx_flow_on = 1'b1;
      tx_flow_on = 1'b1;
      flow_en = 1'b0;
      owed_results.delete();
      mismatch_count_o = 0;
      pending_count_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (owed_results.size() == 0) report_mismatch("result with no event pending");
        else check_result(owed_results.pop_front());
      end
      if (cfg_i.valid && cfg_i.ready) flow_en = cfg_i.flow_enable;
      if (evt_i.valid && evt_i.ready) begin
        owed_results.push_back(serve_event(evt_i.mode, evt_i.data_byte,
                                           evt_i.framing_error, evt_i.overrun_error));
      end
      pending_count_o = owed_results.size();
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART ring pair with XON/XOFF flow control - testbench
// Drives line bytes, host puts and gets and transmitter-ready events through
// directed cases and random bursts under three idling patterns, with flow
// control switched off and on; a side checker predicts every result.
// ----------------------------------------------------------------------------
module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned pending_count;
  // chance in a hundred that the sender or the receiver idles on a cycle
  int unsigned send_idle_pct;
  int unsigned take_idle_pct;

  uxf_evt_if evt ();
  uxf_res_if res ();
  uxf_cfg_if cfg ();

  uart_fifo_xon_xoff_flow i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  uxf_ring_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_i            (evt),
    .res_i            (res),
    .cfg_i            (cfg),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver side: drop ready at random, one decision per falling edge.
  always @(negedge clk_i) begin
    res.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // Present one event and hold it until the block takes the transaction.
  // Entered and left at a falling edge; valid stays high into the next
  // event unless the sender decides to idle first.
  task automatic send_event(input logic [1:0] mode, input logic [7:0] b,
                            input logic ferr, input logic oerr);
    while ($urandom_range(99) < send_idle_pct) begin
      evt.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt.valid         <= 1'b1;
    evt.mode          <= mode;
    evt.data_byte     <= b;
    evt.framing_error <= ferr;
    evt.overrun_error <= oerr;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every owed result has come back. Every event
  // yields a result, so the block is idle once nothing is pending.
  task automatic wait_drained();
    evt.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic write_flow_enable(input logic en);
    wait_drained();
    cfg.valid       <= 1'b1;
    cfg.flow_enable <= en;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // Back-to-back run of one event kind with random data; long enough to
  // fill a ring past its usable depth.
  task automatic fill_burst(input logic [1:0] mode, input int unsigned count);
    repeat (count) send_event(mode, 8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  // Random traffic as bursts: line bytes (with flow characters and errored
  // bytes sprinkled in), gets, puts, transmitter-ready, and fully random
  // noise. Bursts up to 70 long push the rings through full and empty.
  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      len = (kind < 7) ? $urandom_range(70, 1) : $urandom_range(30, 1);
      repeat (len) begin
        b = 8'($urandom_range(255));
        case (kind)
          0, 1, 2: begin
            if ($urandom_range(7) == 0) b = uxf_pkg::CH_XOFF;
            else if ($urandom_range(6) == 0) b = uxf_pkg::CH_XON;
            send_event(uxf_pkg::MODE_LINE_RX, b, $urandom_range(9) == 0,
                       $urandom_range(9) == 0);
          end
          3, 4: send_event(uxf_pkg::MODE_GET, b, 1'($urandom_range(1)),
                           1'($urandom_range(1)));
          5: send_event(uxf_pkg::MODE_PUT, b, 1'b0, 1'b0);
          6: send_event(uxf_pkg::MODE_TX_RDY, b, 1'b0, 1'b0);
          default: begin
            send_event(2'($urandom_range(3)), b, 1'($urandom_range(1)),
                       1'($urandom_range(1)));
          end
        endcase
      end
      sent += len;
    end
  endtask

  initial begin
    // Drive every block input from time zero and hold reset before releasing it.
    rst_ni            = 1'b0;
    evt.valid         = 1'b0;
    evt.mode          = uxf_pkg::MODE_LINE_RX;
    evt.data_byte     = 8'h00;
    evt.framing_error = 1'b0;
    evt.overrun_error = 1'b0;
    cfg.valid         = 1'b0;
    cfg.flow_enable   = 1'b0;
    res.ready         = 1'b0;
    send_idle_pct     = 35;
    take_idle_pct     = 67;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: flow control off after reset. Empty get and empty
    // transmit, put and send both byte extremes, errored line bytes
    // dropped, and a flow character queued as plain data.
    send_event(uxf_pkg::MODE_GET, 8'h00, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_TX_RDY, 8'h00, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_PUT, 8'h00, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_PUT, 8'hFF, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_TX_RDY, 8'h00, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_TX_RDY, 8'h00, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_LINE_RX, 8'hFF, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_LINE_RX, 8'h5A, 1'b1, 1'b0);
    send_event(uxf_pkg::MODE_LINE_RX, 8'h5A, 1'b0, 1'b1);
    send_event(uxf_pkg::MODE_LINE_RX, 8'h5A, 1'b1, 1'b1);
    send_event(uxf_pkg::MODE_GET, 8'h00, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_LINE_RX, uxf_pkg::CH_XOFF, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_GET, 8'h00, 1'b0, 1'b0);

    // Directed: flow control on. XOFF from the partner holds the transmit
    // ring, a second XOFF while held is data, XON resumes, and an XON while
    // running is data as well.
    write_flow_enable(1'b1);
    send_event(uxf_pkg::MODE_LINE_RX, uxf_pkg::CH_XOFF, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_PUT, 8'hA5, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_TX_RDY, 8'h00, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_LINE_RX, uxf_pkg::CH_XOFF, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_LINE_RX, uxf_pkg::CH_XON, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_TX_RDY, 8'h00, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_LINE_RX, uxf_pkg::CH_XON, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_GET, 8'h00, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_GET, 8'h00, 1'b0, 1'b0);
    send_event(uxf_pkg::MODE_GET, 8'h00, 1'b0, 1'b0);

    // Phase 1, flow on, sender idles lightly and receiver heavily. Fill the
    // receive ring past full to raise XOFF and overwrite the oldest bytes,
    // then drain it empty to send XON.
    wait_drained();
    send_idle_pct = 35;
    take_idle_pct = 67;
    fill_burst(uxf_pkg::MODE_LINE_RX, 66);
    fill_burst(uxf_pkg::MODE_GET, 66);
    run_traffic(120);

    // Phase 2, flow off, idling swapped.
    write_flow_enable(1'b0);
    send_idle_pct = 67;
    take_idle_pct = 35;
    run_traffic(250);

    // Phase 3, flow on, no idling. Resume the transmit ring if it was held,
    // then overfill it so puts get refused, and empty it again.
    write_flow_enable(1'b1);
    send_idle_pct = 0;
    take_idle_pct = 0;
    send_event(uxf_pkg::MODE_LINE_RX, uxf_pkg::CH_XON, 1'b0, 1'b0);
    fill_burst(uxf_pkg::MODE_PUT, 66);
    fill_burst(uxf_pkg::MODE_TX_RDY, 66);
    run_traffic(120);

    // Let the last results come home, then keep watching for strays.
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
